// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the top level of the matrix multiply block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(name, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("%m: assertion failed");

// When the antecedent holds, the consequent holds in the same cycle.
`define ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// When the antecedent holds, the consequent holds in the next cycle.
`define ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

// ===== rtl/core/sqmm_pkg.sv =====
// Package with the command codes, widths and state type of the matrix multiply block.
package sqmm_pkg;

    localparam int CMD_W = 2;
    localparam int IDX_W = 4;
    localparam int VAL_W = 16;
    localparam int ACC_W = 32;

    localparam logic [CMD_W-1:0] CMD_WRITE_A = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE_B = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ROW     = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

endpackage

// ===== rtl/core/sqmm_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
module sqmm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/square_matrix_multiply.sv =====
// Top level of the matrix multiply block: element loads, row sequencer and MAC pipeline.
// A load of one element of A or B leaves busy low, so while no row is running, loads
// can follow each other in every cycle. A row request keeps busy high until every
// multiply-accumulate of the row has been issued, because one read port on each
// matrix memory feeds a single shared MAC; its N results, C[row][0] through
// C[row][N-1], appear on strobe in that order, and the last of them carries last.
// Results cannot be held off: each is valid for the single cycle in which strobe
// is high. The next item may be started as soon as busy falls, while the final
// results of a row are still leaving the pipeline. A request for a row that is not
// below N, a load outside the matrix and the unused command code do nothing.
`include "assert_macros.svh"

module square_matrix_multiply #(
    parameter int MATRIX_SIZE = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [sqmm_pkg::CMD_W-1:0]     cmd,
    input  logic [sqmm_pkg::IDX_W-1:0]     row,
    input  logic [sqmm_pkg::IDX_W-1:0]     col,
    input  logic signed [sqmm_pkg::VAL_W-1:0] value,
    output logic                           strobe,
    output logic [sqmm_pkg::IDX_W-1:0]     row_res,
    output logic [sqmm_pkg::IDX_W-1:0]     col_res,
    output logic signed [sqmm_pkg::ACC_W-1:0] product,
    output logic                           last
);

    import sqmm_pkg::*;

    localparam int CELLS = MATRIX_SIZE * MATRIX_SIZE;
    localparam int IW    = (MATRIX_SIZE > 1) ? $clog2(MATRIX_SIZE) : 1;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;

    state_t state_reg, state_next;

    logic [IDX_W-1:0] row_reg, row_next;
    logic [IW-1:0]    k_reg, k_next;
    logic [IW-1:0]    j_reg, j_next;

    logic accept;
    logic row_ok;
    logic col_ok;
    logic k_last;
    logic j_last;
    logic issue;

    logic             a_we, b_we;
    logic [AW-1:0]    waddr;
    logic [AW-1:0]    a_raddr, b_raddr;
    logic [VAL_W-1:0] a_rdata, b_rdata;

    // Stage 1: memory read in flight.
    logic             s1_valid_reg;
    logic             s1_first_reg;
    logic             s1_last_reg;
    logic [IW-1:0]    s1_col_reg;
    logic [IDX_W-1:0] s1_row_reg;

    // Stage 2: product registered.
    logic                    s2_valid_reg;
    logic                    s2_first_reg;
    logic                    s2_last_reg;
    logic [IW-1:0]           s2_col_reg;
    logic [IDX_W-1:0]        s2_row_reg;
    logic signed [ACC_W-1:0] s2_prod_reg;

    logic [ACC_W-1:0] acc_reg, acc_next;
    logic             acc_emit;

    logic                    strobe_reg;
    logic [IDX_W-1:0]        row_res_reg;
    logic [IDX_W-1:0]        col_res_reg;
    logic signed [ACC_W-1:0] product_reg;
    logic                    last_reg;

    assign accept = start && !busy;
    assign row_ok = 32'(row) < 32'(MATRIX_SIZE);
    assign col_ok = 32'(col) < 32'(MATRIX_SIZE);
    assign k_last = k_reg == IW'(MATRIX_SIZE - 1);
    assign j_last = j_reg == IW'(MATRIX_SIZE - 1);
    assign issue  = state_reg == ST_RUN;

    assign a_we  = accept && (cmd == CMD_WRITE_A) && row_ok && col_ok;
    assign b_we  = accept && (cmd == CMD_WRITE_B) && row_ok && col_ok;
    assign waddr = AW'(32'(row) * 32'(MATRIX_SIZE) + 32'(col));

    // A walks along the requested row, B down column j.
    assign a_raddr = AW'(32'(row_reg) * 32'(MATRIX_SIZE) + 32'(k_reg));
    assign b_raddr = AW'(32'(k_reg) * 32'(MATRIX_SIZE) + 32'(j_reg));

    sqmm_ram #(
        .WIDTH (VAL_W),
        .DEPTH (CELLS)
    ) u_left_ram (
        .clk   (clk),
        .we    (a_we),
        .waddr (waddr),
        .wdata (value),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    sqmm_ram #(
        .WIDTH (VAL_W),
        .DEPTH (CELLS)
    ) u_right_ram (
        .clk   (clk),
        .we    (b_we),
        .waddr (waddr),
        .wdata (value),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        k_next     = k_reg;
        j_next     = j_reg;
        busy       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                // Busy is low in this state, so start alone marks an accepted beat.
                if (start && (cmd == CMD_ROW) && row_ok)
                begin
                    state_next = ST_RUN;
                    row_next   = row;
                    k_next     = '0;
                    j_next     = '0;
                end
            end
            ST_RUN:
            begin
                busy = 1'b1;
                if (k_last)
                begin
                    k_next = '0;
                    if (j_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        j_next = j_reg + IW'(1);
                    end
                end
                else
                begin
                    k_next = k_reg + IW'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            row_reg   <= '0;
            k_reg     <= '0;
            j_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            k_reg     <= k_next;
            j_reg     <= j_next;
        end
    end

    // The first term of a column replaces the running sum instead of adding to it.
    assign acc_next = (s2_first_reg ? '0 : acc_reg) + ACC_W'(s2_prod_reg);
    assign acc_emit = s2_valid_reg && s2_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= issue;
            s2_valid_reg <= s1_valid_reg;
            strobe_reg   <= acc_emit;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_first_reg <= k_reg == '0;
        s1_last_reg  <= k_last;
        s1_col_reg   <= j_reg;
        s1_row_reg   <= row_reg;

        s2_first_reg <= s1_first_reg;
        s2_last_reg  <= s1_last_reg;
        s2_col_reg   <= s1_col_reg;
        s2_row_reg   <= s1_row_reg;
        s2_prod_reg  <= $signed(a_rdata) * $signed(b_rdata);

        if (s2_valid_reg)
        begin
            acc_reg <= acc_next;
        end
        if (acc_emit)
        begin
            row_res_reg <= s2_row_reg;
            col_res_reg <= IDX_W'(s2_col_reg);
            product_reg <= $signed(acc_next);
            last_reg    <= s2_col_reg == IW'(MATRIX_SIZE - 1);
        end
    end

    assign strobe  = strobe_reg;
    assign row_res = row_res_reg;
    assign col_res = col_res_reg;
    assign product = product_reg;
    assign last    = last_reg;

    `ASSERT_IMP(a_no_write_in_run, state_reg == ST_RUN, !a_we && !b_we)
    `ASSERT_NEXT(a_row_starts_run, accept && (cmd == CMD_ROW) && row_ok, busy)
    `ASSERT_NEXT(a_emit_strobes, acc_emit, strobe)
    `ASSERT_IMP(a_last_col, strobe && last, col_res == IDX_W'(MATRIX_SIZE - 1))

endmodule
